### src/gbcm_pkg.sv
// ----------------------------------------------------------------------------
// gbcm_pkg
// Shared constants, codes and types for the grid border cell marker.
// ----------------------------------------------------------------------------
package gbcm_pkg;

    // Default grid capacity and window limit
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int MAX_BORDER = 7;

    // Field widths
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int CLS_W   = 2;
    localparam int GDIM_W  = 7;
    localparam int BW_W    = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Headroom for the window mask: widest window is 2*(2**BW_W - 1) + 1 cells
    localparam int WIN_MAX = 2 ** (BW_W + 1);

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Cell classes
    localparam logic [CLS_W-1:0] CLS_FREE        = 2'd0;
    localparam logic [CLS_W-1:0] CLS_OBSTRUCTION = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BORDER      = 2'd2;
    localparam logic [CLS_W-1:0] CLS_OUTSIDE     = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_BORDER = 2'd2;

    // Register reset values
    localparam logic [GDIM_W-1:0] COLS_RST   = 7'd64;
    localparam logic [GDIM_W-1:0] ROWS_RST   = 7'd64;
    localparam logic [BW_W-1:0]   BORDER_RST = 3'd1;

    // Raw register contents handed to the sequencer
    typedef struct packed {
        logic [GDIM_W-1:0] cols;
        logic [GDIM_W-1:0] rows;
        logic [BW_W-1:0]   border;
    } t_cfg;

endpackage

### src/gbcm_regs.sv
// ----------------------------------------------------------------------------
// gbcm_regs
// APB register file: grid columns, grid rows and border half-width.
// ----------------------------------------------------------------------------
module gbcm_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbcm_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbcm_pkg::PDATA_W-1:0]     pwdata,
    output logic [gbcm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output gbcm_pkg::t_cfg                   o_cfg
);

    logic [gbcm_pkg::GDIM_W-1:0] r_cols;
    logic [gbcm_pkg::GDIM_W-1:0] r_rows;
    logic [gbcm_pkg::BW_W-1:0]   r_border;
    logic [1:0]                  reg_idx;
    logic                        wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Take a write beat in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= gbcm_pkg::COLS_RST;
            r_rows   <= gbcm_pkg::ROWS_RST;
            r_border <= gbcm_pkg::BORDER_RST;
        end else if (wr_en) begin
            case (reg_idx)
                gbcm_pkg::REG_COLS:   r_cols   <= pwdata[gbcm_pkg::GDIM_W-1:0];
                gbcm_pkg::REG_ROWS:   r_rows   <= pwdata[gbcm_pkg::GDIM_W-1:0];
                gbcm_pkg::REG_BORDER: r_border <= pwdata[gbcm_pkg::BW_W-1:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb begin
        case (reg_idx)
            gbcm_pkg::REG_COLS:   prdata = gbcm_pkg::PDATA_W'(r_cols);
            gbcm_pkg::REG_ROWS:   prdata = gbcm_pkg::PDATA_W'(r_rows);
            gbcm_pkg::REG_BORDER: prdata = gbcm_pkg::PDATA_W'(r_border);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.cols   = r_cols;
    assign o_cfg.rows   = r_rows;
    assign o_cfg.border = r_border;

endmodule

### src/gbcm_ram.sv
// ----------------------------------------------------------------------------
// gbcm_ram
// Simple dual-port row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbcm_ram #(
    parameter int DEPTH = gbcm_pkg::MAX_ROWS,
    parameter int WIDTH = gbcm_pkg::MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one row, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/grid_border_cell_marker.sv
// ----------------------------------------------------------------------------
// grid_border_cell_marker
// Obstruction map of an occupancy grid with square-window border queries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  item      in         start & !busy             i_action, i_row, i_col, i_obstructed
//  result    out        o_done (one cycle)        o_cell_class
//  config    in         psel&penable&pwrite       paddr, pwdata (prdata on reads)
//
//  The map is kept one grid row per memory word; each read fetches one whole row.
//  Write inside the grid: read the row, then write it back. Outside: dropped.
//  Query outside the grid: answered without a row read. Query whose own cell is
//  obstructed, whose half-width w is 0, or whose window reaches past the grid
//  edge: answered from its own row. Other queries: one window row read per cycle
//  from the read port. After reset busy stays high while the rows are cleared.
//  The result is shown for one cycle; the next item may be taken meanwhile.
// ----------------------------------------------------------------------------
module grid_border_cell_marker #(
    parameter int MAX_COLS   = gbcm_pkg::MAX_COLS,
    parameter int MAX_ROWS   = gbcm_pkg::MAX_ROWS,
    parameter int MAX_BORDER = gbcm_pkg::MAX_BORDER
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_action,
    input  logic [gbcm_pkg::ROW_W-1:0]       i_row,
    input  logic [gbcm_pkg::COL_W-1:0]       i_col,
    input  logic                             i_obstructed,
    output logic                             o_done,
    output logic [gbcm_pkg::CLS_W-1:0]       o_cell_class,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbcm_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbcm_pkg::PDATA_W-1:0]     pwdata,
    output logic [gbcm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CBW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MW  = MAX_COLS + gbcm_pkg::WIN_MAX;
    localparam int GW  = gbcm_pkg::GDIM_W;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WMOD  = 3'd2;
    localparam logic [2:0] S_QCTR  = 3'd3;
    localparam logic [2:0] S_QSCAN = 3'd4;

    gbcm_pkg::t_cfg cfg;

    logic [GW-1:0]                rows_eff;
    logic [GW-1:0]                cols_eff;
    logic [gbcm_pkg::BW_W-1:0]    w_eff;
    logic                         accept;
    logic                         in_grid;
    logic [GW:0]                  row_hi;
    logic [GW:0]                  col_hi;
    logic                         at_edge;
    logic [gbcm_pkg::BW_W:0]      win_len;
    logic [MW-1:0]                win_ones;
    logic [MW-1:0]                win_shift;
    logic [gbcm_pkg::COL_W-1:0]   col_lo;

    logic                         ram_we;
    logic [RW-1:0]                ram_waddr;
    logic [MAX_COLS-1:0]          ram_wdata;
    logic                         ram_re;
    logic [GW-1:0]                rd_row;
    logic [MAX_COLS-1:0]          ram_rdata;
    logic [MAX_COLS-1:0]          wr_word;
    logic [CBW-1:0]               col_idx;

    logic [2:0]                   r_state, n_state;
    logic [RW-1:0]                r_clr, n_clr;
    logic [gbcm_pkg::COL_W-1:0]   r_col, n_col;
    logic                         r_obs, n_obs;
    logic                         r_wzero, n_wzero;
    logic                         r_edge, n_edge;
    logic [MAX_COLS-1:0]          r_mask, n_mask;
    logic [GW-1:0]                r_first, n_first;
    logic [GW-1:0]                r_last, n_last;
    logic [GW-1:0]                r_drow, n_drow;
    logic                         r_done, n_done;
    logic [gbcm_pkg::CLS_W-1:0]   r_class, n_class;

    gbcm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gbcm_ram #(
        .DEPTH (MAX_ROWS),
        .WIDTH (MAX_COLS),
        .AW    (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (RW'(rd_row)),
        .o_rdata (ram_rdata)
    );

    // Saturate the registers to the built capacity
    assign rows_eff = (32'(cfg.rows) > MAX_ROWS) ? GW'(MAX_ROWS) : cfg.rows;
    assign cols_eff = (32'(cfg.cols) > MAX_COLS) ? GW'(MAX_COLS) : cfg.cols;
    assign w_eff    = (32'(cfg.border) > MAX_BORDER) ?
                      gbcm_pkg::BW_W'(MAX_BORDER) : cfg.border;

    assign accept  = start && !busy;
    assign in_grid = (GW'(i_row) < rows_eff) && (GW'(i_col) < cols_eff);

    // Window reaching past any grid edge
    assign row_hi  = (GW+1)'(i_row) + (GW+1)'(w_eff);
    assign col_hi  = (GW+1)'(i_col) + (GW+1)'(w_eff);
    assign at_edge = (i_row < gbcm_pkg::ROW_W'(w_eff)) || (row_hi >= (GW+1)'(rows_eff)) ||
                     (i_col < gbcm_pkg::COL_W'(w_eff)) || (col_hi >= (GW+1)'(cols_eff));

    // Column mask of the window: 2w+1 ones starting at col - w
    assign win_len   = {w_eff, 1'b1};
    assign win_ones  = (MW'(1) << win_len) - MW'(1);
    assign col_lo    = i_col - gbcm_pkg::COL_W'(w_eff);
    assign win_shift = win_ones << col_lo;

    // Merge the written bit into the row read back
    assign col_idx = CBW'(r_col);
    always_comb begin
        wr_word          = ram_rdata;
        wr_word[col_idx] = r_obs;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_col     = r_col;
        n_obs     = r_obs;
        n_wzero   = r_wzero;
        n_edge    = r_edge;
        n_mask    = r_mask;
        n_first   = r_first;
        n_last    = r_last;
        n_drow    = r_drow;
        n_done    = 1'b0;
        n_class   = r_class;
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        rd_row    = GW'(i_row);

        case (r_state)
            // Zero one row per cycle
            S_CLR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + RW'(1);
                if (r_clr == RW'(MAX_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take an item and, if it lies inside the grid, start the row read
            S_IDLE: begin
                if (accept) begin
                    n_col   = i_col;
                    n_obs   = i_obstructed;
                    n_drow  = GW'(i_row);
                    n_wzero = (w_eff == '0);
                    n_edge  = at_edge;
                    n_mask  = win_shift[MAX_COLS-1:0];
                    n_first = GW'(i_row) - GW'(w_eff);
                    n_last  = row_hi[GW-1:0];
                    if (!in_grid) begin
                        if (i_action == gbcm_pkg::ACT_QUERY) begin
                            n_done  = 1'b1;
                            n_class = gbcm_pkg::CLS_OUTSIDE;
                        end
                    end else begin
                        ram_re  = 1'b1;
                        n_state = (i_action == gbcm_pkg::ACT_WRITE) ? S_WMOD : S_QCTR;
                    end
                end
            end

            // Write back the modified row
            S_WMOD: begin
                ram_we    = 1'b1;
                ram_waddr = RW'(r_drow);
                ram_wdata = wr_word;
                n_state   = S_IDLE;
            end

            // Check the cell itself, then a zero half-width, then the edge, then start the window scan
            S_QCTR: begin
                if (ram_rdata[col_idx]) begin
                    n_done  = 1'b1;
                    n_class = gbcm_pkg::CLS_OBSTRUCTION;
                    n_state = S_IDLE;
                end else if (r_wzero) begin
                    n_done  = 1'b1;
                    n_class = gbcm_pkg::CLS_FREE;
                    n_state = S_IDLE;
                end else if (r_edge) begin
                    n_done  = 1'b1;
                    n_class = gbcm_pkg::CLS_BORDER;
                    n_state = S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    rd_row  = r_first;
                    n_drow  = r_first;
                    n_state = S_QSCAN;
                end
            end

            // Test one window row per cycle while the next is read
            S_QSCAN: begin
                if (|(ram_rdata & r_mask)) begin
                    n_done  = 1'b1;
                    n_class = gbcm_pkg::CLS_BORDER;
                    n_state = S_IDLE;
                end else if (r_drow == r_last) begin
                    n_done  = 1'b1;
                    n_class = gbcm_pkg::CLS_FREE;
                    n_state = S_IDLE;
                end else begin
                    ram_re = 1'b1;
                    rd_row = r_drow + GW'(1);
                    n_drow = r_drow + GW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        r_col   <= n_col;
        r_obs   <= n_obs;
        r_wzero <= n_wzero;
        r_edge  <= n_edge;
        r_mask  <= n_mask;
        r_first <= n_first;
        r_last  <= n_last;
        r_drow  <= n_drow;
        r_class <= n_class;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_cell_class = r_class;

endmodule

### src/gbcm_chk.sv
// ----------------------------------------------------------------------------
// gbcm_chk
// Port-level checks for the grid border cell marker, bound to the top level.
// ----------------------------------------------------------------------------
module gbcm_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_action,
    input logic                       o_done,
    input logic [gbcm_pkg::CLS_W-1:0] o_cell_class,
    input logic                       pready
);

    // Show busy right after reset, when the clearing pass begins
    a_busy_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // Drop no result beat after a write item
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == gbcm_pkg::ACT_WRITE) |=> !o_done)
        else $error("result beat after a write");

    // Advance a query: either busy or an outside answer next cycle
    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == gbcm_pkg::ACT_QUERY) |=>
            (busy || (o_done && o_cell_class == gbcm_pkg::CLS_OUTSIDE)))
        else $error("query neither running nor answered");

    // Map-based answers only come out of a busy cycle
    a_class_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cell_class != gbcm_pkg::CLS_OUTSIDE) |-> $past(busy))
        else $error("map class without a running query");

    // Config port never stalls
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind grid_border_cell_marker gbcm_chk u_gbcm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_done       (o_done),
    .o_cell_class (o_cell_class),
    .pready       (pready)
);

### verif/tb_grid_border_cell_marker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_border_cell_marker
// Self-checking bench: a cell-class predictor shadows the obstruction map and
// the grid registers, and every result beat is compared with the oldest class
// it expects. Directed items cover edges, obstacles and register extremes.
// Random phases under varied register settings follow, with bursty issue.
// ----------------------------------------------------------------------------
module tb_grid_border_cell_marker;

    // ------------------------------------------------------------------------
    // Cell-class predictor: shadow map, shadow registers, expected classes
    // ------------------------------------------------------------------------
    class border_class_predictor;
        bit                           obstacle [0:gbcm_pkg::MAX_ROWS*gbcm_pkg::MAX_COLS-1];
        logic [gbcm_pkg::GDIM_W-1:0]  cols;
        logic [gbcm_pkg::GDIM_W-1:0]  rows;
        logic [gbcm_pkg::BW_W-1:0]    half;
        logic [gbcm_pkg::CLS_W-1:0]   expected_classes [$];
        int                           errors;
        int                           writes;
        int                           queries;
        int                           class_seen [4];

        function new();
            foreach (obstacle[i]) obstacle[i] = 1'b0;
            cols    = gbcm_pkg::COLS_RST;
            rows    = gbcm_pkg::ROWS_RST;
            half    = gbcm_pkg::BORDER_RST;
            errors  = 0;
            writes  = 0;
            queries = 0;
            foreach (class_seen[i]) class_seen[i] = 0;
        endfunction

        function int eff_cols();
            return (int'(cols) > gbcm_pkg::MAX_COLS) ? gbcm_pkg::MAX_COLS : int'(cols);
        endfunction

        function int eff_rows();
            return (int'(rows) > gbcm_pkg::MAX_ROWS) ? gbcm_pkg::MAX_ROWS : int'(rows);
        endfunction

        function int eff_half();
            return (int'(half) > gbcm_pkg::MAX_BORDER) ? gbcm_pkg::MAX_BORDER : int'(half);
        endfunction

        function void set_config(logic [gbcm_pkg::GDIM_W-1:0] c,
                                 logic [gbcm_pkg::GDIM_W-1:0] r,
                                 logic [gbcm_pkg::BW_W-1:0] w);
            cols = c;
            rows = r;
            half = w;
        endfunction

        // Outside, own obstacle, then the window: edge crossing or obstacle is a border
        function logic [gbcm_pkg::CLS_W-1:0] classify(int r, int c);
            int nr;
            int nc;
            int w;
            int rr;
            int cc;
            nr = eff_rows();
            nc = eff_cols();
            w  = eff_half();
            if (r >= nr || c >= nc) return gbcm_pkg::CLS_OUTSIDE;
            if (obstacle[r*gbcm_pkg::MAX_COLS + c]) return gbcm_pkg::CLS_OBSTRUCTION;
            for (int dr = -w; dr <= w; dr++) begin
                for (int dc = -w; dc <= w; dc++) begin
                    rr = r + dr;
                    cc = c + dc;
                    if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) return gbcm_pkg::CLS_BORDER;
                    if (obstacle[rr*gbcm_pkg::MAX_COLS + cc]) return gbcm_pkg::CLS_BORDER;
                end
            end
            return gbcm_pkg::CLS_FREE;
        endfunction

        // Apply an accepted item: update the map or queue the expected class
        function void note_item(logic act, logic [gbcm_pkg::ROW_W-1:0] r,
                                logic [gbcm_pkg::COL_W-1:0] c, logic obs);
            if (act == gbcm_pkg::ACT_WRITE) begin
                writes++;
                if (int'(r) < eff_rows() && int'(c) < eff_cols())
                    obstacle[int'(r)*gbcm_pkg::MAX_COLS + int'(c)] = obs;
            end else begin
                queries++;
                expected_classes.insert(expected_classes.size(),
                                        classify(int'(r), int'(c)));
            end
        endfunction

        function void check_class(logic [gbcm_pkg::CLS_W-1:0] got);
            logic [gbcm_pkg::CLS_W-1:0] want;
            if (expected_classes.size() == 0) begin
                $error("cell_class: unexpected result beat, actual %0d", got);
                errors++;
                return;
            end
            want = expected_classes.pop_front();
            class_seen[want]++;
            if (got !== want) begin
                $error("cell_class mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_classes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_action;
    logic [gbcm_pkg::ROW_W-1:0]    i_row;
    logic [gbcm_pkg::COL_W-1:0]    i_col;
    logic                          i_obstructed;
    logic                          o_done;
    logic [gbcm_pkg::CLS_W-1:0]    o_cell_class;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [gbcm_pkg::PADDR_W-1:0]  paddr;
    logic [gbcm_pkg::PDATA_W-1:0]  pwdata;
    logic [gbcm_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    border_class_predictor sb;
    int                    burst_left;
    int                    settings;

    grid_border_cell_marker u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_obstructed (i_obstructed),
        .o_done       (o_done),
        .o_cell_class (o_cell_class),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5000000;
        $display("tb_grid_border_cell_marker NOT OK");
        $finish;
    end

    // Check every result beat against the oldest expected class
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_class(o_cell_class);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Issue one item beat; drop start for a random gap at the end of a burst
    task automatic issue(logic act, int r, int c, logic obs);
        int gap;
        i_action     <= act;
        i_row        <= r[gbcm_pkg::ROW_W-1:0];
        i_col        <= c[gbcm_pkg::COL_W-1:0];
        i_obstructed <= obs;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(act, r[gbcm_pkg::ROW_W-1:0], c[gbcm_pkg::COL_W-1:0], obs);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 20);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 24);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold until nothing is in flight, then let a write finish its cycles
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [gbcm_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(int c, int r, int w);
        settle();
        apb_write(gbcm_pkg::REG_COLS, c);
        apb_write(gbcm_pkg::REG_ROWS, r);
        apb_write(gbcm_pkg::REG_BORDER, w);
        sb.set_config(c[gbcm_pkg::GDIM_W-1:0], r[gbcm_pkg::GDIM_W-1:0],
                      w[gbcm_pkg::BW_W-1:0]);
        settings++;
    endtask

    // Mostly inside the grid, sometimes clustered near a focus, else anywhere
    function automatic int pick_coord(int lim, int focus);
        int sel;
        sel = $urandom_range(0, 9);
        if (lim > 0 && sel < 5) return $urandom_range(0, lim - 1);
        if (sel < 8) return (focus + $urandom_range(0, 7)) % 64;
        return $urandom_range(0, 63);
    endfunction

    function automatic int pick_dim();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 0;
        if (sel < 3) return $urandom_range(65, 127);
        if (sel < 11) return $urandom_range(1, 16);
        return $urandom_range(17, 64);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int pct_obs;
        int pct_query;
        int fr;
        int fc;
        int act;
        sb           = new();
        burst_left   = 0;
        settings     = 0;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= gbcm_pkg::ACT_WRITE;
        i_row        <= '0;
        i_col        <= '0;
        i_obstructed <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset registers, grid edges, single obstacle and its halo
        issue(gbcm_pkg::ACT_QUERY, 0, 0, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 20, 20, 1'b1);
        issue(gbcm_pkg::ACT_QUERY, 63, 63, 1'b0);
        issue(gbcm_pkg::ACT_WRITE, 20, 20, 1'b1);
        issue(gbcm_pkg::ACT_QUERY, 20, 20, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 21, 21, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 22, 22, 1'b0);
        issue(gbcm_pkg::ACT_WRITE, 20, 20, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 21, 21, 1'b0);
        issue(gbcm_pkg::ACT_WRITE, 63, 0, 1'b1);
        issue(gbcm_pkg::ACT_QUERY, 63, 0, 1'b0);

        // Empty grid: queries answer outside, writes are dropped
        set_grid(0, 64, 0);
        issue(gbcm_pkg::ACT_QUERY, 5, 5, 1'b0);
        issue(gbcm_pkg::ACT_WRITE, 5, 5, 1'b1);

        // Oversized registers saturate; zero half-width keeps free cells free
        set_grid(127, 127, 0);
        issue(gbcm_pkg::ACT_QUERY, 5, 5, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 0, 0, 1'b0);

        // Small grid, widest window, writes and queries past the grid
        set_grid(5, 3, 7);
        issue(gbcm_pkg::ACT_WRITE, 2, 10, 1'b1);
        issue(gbcm_pkg::ACT_QUERY, 2, 4, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 3, 0, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 0, 5, 1'b0);

        // Grow back: bits kept across the resize, and the dropped write leaves no obstacle
        set_grid(64, 64, 7);
        issue(gbcm_pkg::ACT_QUERY, 2, 10, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 30, 30, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 56, 7, 1'b0);
        issue(gbcm_pkg::ACT_WRITE, 63, 0, 1'b0);
        issue(gbcm_pkg::ACT_QUERY, 1, 1, 1'b0);

        // Random phases, each under its own register setting
        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       set_grid(64, 64, 7);
                1:       set_grid(1, 1, 1);
                2:       set_grid(64, 64, 0);
                default: set_grid(pick_dim(), pick_dim(), $urandom_range(0, 7));
            endcase
            case ($urandom_range(0, 3))
                0:       pct_obs = 3;
                1:       pct_obs = 12;
                2:       pct_obs = 30;
                default: pct_obs = 60;
            endcase
            pct_query = $urandom_range(35, 70);
            fr = $urandom_range(0, 63);
            fc = $urandom_range(0, 63);
            for (int k = 0; k < 155; k++) begin
                act = ($urandom_range(0, 99) < pct_query) ?
                      gbcm_pkg::ACT_QUERY : gbcm_pkg::ACT_WRITE;
                issue(act[0], pick_coord(sb.eff_rows(), fr),
                      pick_coord(sb.eff_cols(), fc),
                      ($urandom_range(0, 99) < pct_obs) ? 1'b1 : 1'b0);
            end
        end

        // Drain and finish
        settle();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d writes and %0d queries over %0d register settings",
                 sb.writes, sb.queries, settings);
        $display("Classes seen: free %0d, obstruction %0d, border %0d, outside %0d",
                 sb.class_seen[gbcm_pkg::CLS_FREE],
                 sb.class_seen[gbcm_pkg::CLS_OBSTRUCTION],
                 sb.class_seen[gbcm_pkg::CLS_BORDER],
                 sb.class_seen[gbcm_pkg::CLS_OUTSIDE]);
        if (sb.pending() != 0) begin
            $error("cell_class: %0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_grid_border_cell_marker OK");
        end else begin
            $display("tb_grid_border_cell_marker NOT OK");
        end
        $finish;
    end

endmodule
